// ===== rtl/core/present80_block_encrypt_core_assert.svh =====
// Assertion macros for the PRESENT-80 encryption core.
`ifndef PRESENT80_BLOCK_ENCRYPT_CORE_ASSERT_SVH
`define PRESENT80_BLOCK_ENCRYPT_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define P80_ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define P80_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define P80_ASSERT_RST(label, clk, rstn, prop, msg)
`define P80_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ===== rtl/core/p80_pkg.sv =====
// Shared types, constants and layer functions of the PRESENT-80 core.
package p80_pkg;

    localparam int BlockW    = 64;
    localparam int KeyW      = 80;
    localparam int KeyLowW   = 64;
    localparam int KeyHighW  = 16;
    localparam int NumRounds = 31;
    localparam int RcW       = 5;
    localparam int CfgIdxW   = 8;
    localparam int CfgDataW  = 64;

    localparam logic [CfgIdxW-1:0] CFG_KEY_LOW  = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_KEY_HIGH = 8'd1;

    localparam logic [3:0] SBOX [16] = '{
        4'd12, 4'd5, 4'd6, 4'd11, 4'd9, 4'd0, 4'd10, 4'd13,
        4'd3, 4'd14, 4'd15, 4'd8, 4'd4, 4'd7, 4'd1, 4'd2
    };

    typedef struct packed {
        logic [BlockW-1:0] state;
        logic [KeyW-1:0]   key;
    } round_t;

    function automatic logic [BlockW-1:0] sub_layer(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] r;
        r = '0;
        for (int i = 0; i < BlockW / 4; i++) begin
            r[4*i +: 4] = SBOX[s[4*i +: 4]];
        end
        return r;
    endfunction

    function automatic logic [BlockW-1:0] perm_layer(input logic [BlockW-1:0] s);
        logic [BlockW-1:0] r;
        logic [5:0]        b;
        r = '0;
        for (int i = 0; i < BlockW; i++) begin
            b = 6'(i);
            r[{b[1:0], b[5:2]}] = s[b];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/present80_block_encrypt_core.sv =====
// Top level of the pipelined PRESENT-80 block encryption core.
//
// Usage:
//   The key is loaded through the configuration channel (cfg_valid, cfg_ready,
//   cfg_index, cfg_data): index 0 holds key bits 63..0, index 1 holds key bits
//   79..64; other indexes are ignored. cfg_ready is always high. Write the key
//   only while no block is in flight.
//   Plaintext beats enter on s_valid/s_ready/s_plaintext, ciphertext beats leave
//   on m_valid/m_ready/m_ciphertext, in order.
//   Each of the 31 rounds, with its key update, is one pipeline stage; a final
//   output register applies the last key addition. One beat is accepted every
//   cycle while the receiver does not stall.
//   When the receiver stalls with a beat waiting, the whole pipeline holds and
//   s_ready drops in the same cycle; nothing is dropped or repeated.
//   Reset (aresetn low, synchronous) clears the key to zero and empties the
//   pipeline.
`include "present80_block_encrypt_core_assert.svh"

module present80_block_encrypt_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [p80_pkg::CfgIdxW-1:0]      cfg_index,
    input  logic [p80_pkg::CfgDataW-1:0]     cfg_data,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [p80_pkg::BlockW-1:0]       s_plaintext,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [p80_pkg::BlockW-1:0]       m_ciphertext
);

    localparam int Last = p80_pkg::NumRounds - 1;

    logic [p80_pkg::KeyLowW-1:0]  key_low_reg;
    logic [p80_pkg::KeyHighW-1:0] key_high_reg;

    p80_pkg::round_t              stage_in  [p80_pkg::NumRounds];
    p80_pkg::round_t              stage_next[p80_pkg::NumRounds];
    p80_pkg::round_t              stage_reg [p80_pkg::NumRounds];
    logic [p80_pkg::NumRounds-1:0] valid_reg;

    logic                         m_valid_reg;
    logic [p80_pkg::BlockW-1:0]   m_ciphertext_reg;
    logic                         advance;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg  <= '0;
            key_high_reg <= '0;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                p80_pkg::CFG_KEY_LOW: begin
                    key_low_reg <= cfg_data;
                end
                p80_pkg::CFG_KEY_HIGH: begin
                    key_high_reg <= cfg_data[p80_pkg::KeyHighW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    assign stage_in[0].state = s_plaintext;
    assign stage_in[0].key   = {key_high_reg, key_low_reg};

    genvar g;
    generate
        for (g = 0; g < p80_pkg::NumRounds; g++) begin : g_round
            if (g > 0) begin : g_link
                assign stage_in[g] = stage_reg[g-1];
            end
            p80_round u_round (
                .cur (stage_in[g]),
                .rc  (p80_pkg::RcW'(g + 1)),
                .nxt (stage_next[g])
            );
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (advance) begin
            valid_reg <= {valid_reg[Last-1:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int i = 0; i < p80_pkg::NumRounds; i++) begin
                stage_reg[i] <= stage_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= valid_reg[Last];
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_ciphertext_reg <= stage_reg[Last].state
                                ^ stage_reg[Last].key[p80_pkg::KeyW-1:16];
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_ciphertext = m_ciphertext_reg;

    `P80_ASSERT_RST(a_last_stage_holds, aclk, aresetn,
        (valid_reg[Last] && !advance) |=> valid_reg[Last],
        "last round stage lost its beat during a stall")
    `P80_ASSERT_RST(a_out_from_pipe, aclk, aresetn,
        $rose(m_valid_reg) |-> $past(valid_reg[Last]),
        "output beat appeared without a beat in the last round stage")
    `P80_ASSERT_RST(a_stall_freezes_entry, aclk, aresetn,
        !advance |=> $stable(valid_reg[0]),
        "first round stage changed while the pipeline was stalled")
    `P80_ASSERT_ALWAYS(a_reset_empties, aclk,
        !aresetn |=> (!m_valid_reg && (valid_reg == '0)),
        "pipeline not empty after reset")

endmodule

// ===== rtl/core/p80_round.sv =====
// One PRESENT-80 round: key addition, S-box layer, bit permutation and key update.
module p80_round (
    input  p80_pkg::round_t              cur,
    input  logic [p80_pkg::RcW-1:0]      rc,
    output p80_pkg::round_t              nxt
);

    logic [p80_pkg::KeyW-1:0] rot;
    logic [p80_pkg::KeyW-1:0] key_upd;

    assign rot = {cur.key[18:0], cur.key[p80_pkg::KeyW-1:19]};

    always_comb begin
        key_upd          = rot;
        key_upd[79:76]   = p80_pkg::SBOX[rot[79:76]];
        key_upd[19:15]   = rot[19:15] ^ rc;
    end

    assign nxt.state = p80_pkg::perm_layer(
        p80_pkg::sub_layer(cur.state ^ cur.key[p80_pkg::KeyW-1:16]));
    assign nxt.key   = key_upd;

endmodule
